/* design/ldrbox_pkg.sv */
// Shared types, constants and the sRGB-to-linear table for the box downsampler.
package ldrbox_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int SIZE_W     = 9;
    localparam int CHCNT_W    = 3;
    localparam int BYTE_W     = 8;
    localparam int NUM_CH     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int LIN_W      = 25;
    localparam int AREA_W     = 18;
    localparam int SUM_W      = 42;
    localparam int PROD_W     = LIN_W + AREA_W;
    localparam int NUM_W      = 27;
    localparam int DEN_W      = AREA_W;
    localparam int ROM_DEPTH  = 256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT,
        REG_DST_WIDTH,
        REG_DST_HEIGHT,
        REG_CHANNEL_COUNT,
        REG_COLOR_SEMANTIC,
        REG_SRGB_SPACE
    } reg_index_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_CAPTURE,
        CMD_DIV,
        CMD_SETUP,
        CMD_READ,
        CMD_ACC,
        CMD_SEARCH_INIT,
        CMD_SEARCH_MUL,
        CMD_SEARCH_CMP,
        CMD_MUL_UP,
        CMD_MUL_DN,
        CMD_SRGB_DONE,
        CMD_NEXT_CH,
        CMD_PUBLISH
    } dp_cmd_t;

    typedef enum logic [2:0] {
        DIV_BX,
        DIV_EX,
        DIV_BY,
        DIV_EY,
        DIV_MEAN
    } div_sel_t;

    typedef struct packed {
        dp_cmd_t  cmd;
        div_sel_t sel;
    } dp_ctl_t;

    typedef struct packed {
        logic query;
        logic bad;
        logic div_done;
        logic last;
        logic ch_used;
        logic ch_srgb;
        logic ch_last;
        logic search_done;
        logic out_free;
    } dp_stat_t;

    typedef logic [LIN_W-1:0] lin_rom_t [ROM_DEPTH];

    // Q24 linear light per sRGB code; linear segment below code 11
    function automatic lin_rom_t build_lin_rom();
        lin_rom_t rom;
        real      v;
        longint   lin;
        for (int c = 0; c < ROM_DEPTH; c++) begin
            if (c <= 10) begin
                lin = (longint'(c) * 64'd335544320 + 64'd32946) / 64'd65892;
                rom[c] = LIN_W'(lin);
            end
            else begin
                v = (real'(c) * 1000.0 + 14025.0) / 269025.0;
                v = 16777216.0 * $pow(v, 2.4);
                rom[c] = LIN_W'($rtoi(v + 0.5));
            end
        end
        return rom;
    endfunction

    localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

/* design/ldrbox_div.sv */
// Restoring divider, one quotient bit per cycle.
module ldrbox_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ldrbox_pkg::NUM_W-1:0] num,
    input  logic [ldrbox_pkg::DEN_W-1:0] den,
    output logic                         done,
    output logic [ldrbox_pkg::NUM_W-1:0] quo
);
    import ldrbox_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign rem_sh = {rem_reg, quo_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* design/ldrbox_dp.sv */
// Datapath: config registers, image store, box walk, sums, divide and sRGB search.
module ldrbox_dp #(
    parameter int MAX_WIDTH  = ldrbox_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ldrbox_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ldrbox_pkg::dp_ctl_t               ctl,
    output ldrbox_pkg::dp_stat_t              stat,
    input  logic                              action,
    input  logic [ldrbox_pkg::BYTE_W-1:0]     texel_x,
    input  logic [ldrbox_pkg::BYTE_W-1:0]     texel_y,
    input  logic [ldrbox_pkg::BYTE_W-1:0]     in_ch0,
    input  logic [ldrbox_pkg::BYTE_W-1:0]     in_ch1,
    input  logic [ldrbox_pkg::BYTE_W-1:0]     in_ch2,
    input  logic [ldrbox_pkg::BYTE_W-1:0]     in_ch3,
    input  logic                              cfg_valid,
    input  logic [ldrbox_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ldrbox_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [ldrbox_pkg::BYTE_W-1:0]     out_ch0,
    output logic [ldrbox_pkg::BYTE_W-1:0]     out_ch1,
    output logic [ldrbox_pkg::BYTE_W-1:0]     out_ch2,
    output logic [ldrbox_pkg::BYTE_W-1:0]     out_ch3,
    output logic                              bad_coord
);
    import ldrbox_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W = NUM_CH * BYTE_W;

    function automatic logic srgb_of(logic [1:0] k, logic [CHCNT_W-1:0] n,
                                     logic cs, logic ss);
        logic alpha;
        alpha = cs && ((n == CHCNT_W'(2) && k == 2'd1) || (n == CHCNT_W'(4) && k == 2'd3));
        return cs && ss && !alpha;
    endfunction

    // configuration
    logic [SIZE_W-1:0]  src_width_reg, src_height_reg, dst_width_reg, dst_height_reg;
    logic [CHCNT_W-1:0] channel_count_reg;
    logic               color_semantic_reg, srgb_space_reg;

    logic [SIZE_W-1:0]  sw, sh, dw, dh;
    logic [CHCNT_W-1:0] nch;

    // query work registers
    logic [BYTE_W-1:0]  qx_reg, qy_reg;
    logic [SIZE_W-1:0]  bx_reg, ex_reg, by_reg, ey_reg, sx_reg, sy_reg;
    logic [AREA_W-1:0]  count_reg;
    logic [WORD_W-1:0]  mem_q;
    logic               last_reg;
    logic [SUM_W-1:0]   sum_reg [NUM_CH];
    logic [1:0]         ch_reg;
    logic [SIZE_W-1:0]  lo_reg, hi_reg;
    logic [PROD_W-1:0]  prod_reg, up_reg;
    logic [BYTE_W-1:0]  res_reg [NUM_CH];
    logic               res_bad_reg;
    div_sel_t           div_sel_reg;

    // output slot
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_ch_reg [NUM_CH];
    logic               out_bad_reg;

    logic [WORD_W-1:0]  mem [DEPTH];
    logic [AW-1:0]      wr_addr, rd_addr;
    logic               wr_en;

    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;
    logic [NUM_W-1:0]   div_quo;

    logic [SIZE_W:0]    mid_sum;
    logic [7:0]         mid;
    logic [SUM_W-1:0]   add_val [NUM_CH];
    logic [SIZE_W-1:0]  end_x, end_y;
    logic [SUM_W-1:0]   cur_sum;
    logic [PROD_W-1:0]  up_gap, dn_gap;

    always_comb
    begin
        if (src_width_reg == '0)
            sw = SIZE_W'(1);
        else if (32'(src_width_reg) > MAX_WIDTH)
            sw = SIZE_W'(MAX_WIDTH);
        else
            sw = src_width_reg;
        if (src_height_reg == '0)
            sh = SIZE_W'(1);
        else if (32'(src_height_reg) > MAX_HEIGHT)
            sh = SIZE_W'(MAX_HEIGHT);
        else
            sh = src_height_reg;
        dw = (dst_width_reg == '0) ? SIZE_W'(1) : dst_width_reg;
        dh = (dst_height_reg == '0) ? SIZE_W'(1) : dst_height_reg;
        if (channel_count_reg == '0)
            nch = CHCNT_W'(1);
        else if (channel_count_reg > CHCNT_W'(4))
            nch = CHCNT_W'(4);
        else
            nch = channel_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg      <= SIZE_W'(1);
            src_height_reg     <= SIZE_W'(1);
            dst_width_reg      <= SIZE_W'(1);
            dst_height_reg     <= SIZE_W'(1);
            channel_count_reg  <= CHCNT_W'(4);
            color_semantic_reg <= 1'b1;
            srgb_space_reg     <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:      src_width_reg      <= cfg_data;
                REG_SRC_HEIGHT:     src_height_reg     <= cfg_data;
                REG_DST_WIDTH:      dst_width_reg      <= cfg_data;
                REG_DST_HEIGHT:     dst_height_reg     <= cfg_data;
                REG_CHANNEL_COUNT:  channel_count_reg  <= cfg_data[CHCNT_W-1:0];
                REG_COLOR_SEMANTIC: color_semantic_reg <= cfg_data[0];
                REG_SRGB_SPACE:     srgb_space_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // image store
    assign wr_en   = ctl.cmd == CMD_LOAD && 32'(texel_x) < MAX_WIDTH
                     && 32'(texel_y) < MAX_HEIGHT;
    assign wr_addr = AW'(32'(texel_y) * MAX_WIDTH + 32'(texel_x));
    assign rd_addr = AW'(32'(sy_reg) * MAX_WIDTH + 32'(sx_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {in_ch3, in_ch2, in_ch1, in_ch0};
        if (ctl.cmd == CMD_READ)
            mem_q <= mem[rd_addr];
    end

    // divider operands
    always_comb
    begin
        case (ctl.sel)
            DIV_BX:
            begin
                div_num = NUM_W'(qx_reg) * NUM_W'(sw);
                div_den = DEN_W'(dw);
            end
            DIV_EX:
            begin
                div_num = (NUM_W'(qx_reg) + 1'b1) * NUM_W'(sw) + NUM_W'(dw) - 1'b1;
                div_den = DEN_W'(dw);
            end
            DIV_BY:
            begin
                div_num = NUM_W'(qy_reg) * NUM_W'(sh);
                div_den = DEN_W'(dh);
            end
            DIV_EY:
            begin
                div_num = (NUM_W'(qy_reg) + 1'b1) * NUM_W'(sh) + NUM_W'(dh) - 1'b1;
                div_den = DEN_W'(dh);
            end
            default:
            begin
                div_num = sum_reg[ch_reg][NUM_W-1:0] + NUM_W'(count_reg >> 1);
                div_den = count_reg;
            end
        endcase
    end

    ldrbox_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.cmd == CMD_DIV),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // end bound: clamp to source size, at least one texel past begin
    always_comb
    begin
        end_x = (div_quo > NUM_W'(sw)) ? sw : div_quo[SIZE_W-1:0];
        if (end_x < bx_reg + 1'b1)
            end_x = bx_reg + 1'b1;
        end_y = (div_quo > NUM_W'(sh)) ? sh : div_quo[SIZE_W-1:0];
        if (end_y < by_reg + 1'b1)
            end_y = by_reg + 1'b1;
    end

    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            if (srgb_of(2'(k), nch, color_semantic_reg, srgb_space_reg))
                add_val[k] = SUM_W'(LIN_ROM[mem_q[k*BYTE_W +: BYTE_W]]);
            else
                add_val[k] = SUM_W'(mem_q[k*BYTE_W +: BYTE_W]);
        end
    end

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[8:1];
    assign cur_sum = sum_reg[ch_reg];
    assign up_gap  = up_reg - PROD_W'(cur_sum);
    assign dn_gap  = PROD_W'(cur_sum) - prod_reg;

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            case (div_sel_reg)
                DIV_BX:  bx_reg <= div_quo[SIZE_W-1:0];
                DIV_EX:  ex_reg <= end_x;
                DIV_BY:  by_reg <= div_quo[SIZE_W-1:0];
                DIV_EY:  ey_reg <= end_y;
                default: res_reg[ch_reg] <= div_quo[BYTE_W-1:0];
            endcase
        end
        case (ctl.cmd)
            CMD_CAPTURE:
            begin
                qx_reg      <= texel_x;
                qy_reg      <= texel_y;
                res_bad_reg <= SIZE_W'(texel_x) >= dw || SIZE_W'(texel_y) >= dh;
                for (int k = 0; k < NUM_CH; k++)
                    res_reg[k] <= '0;
            end
            CMD_DIV:
                div_sel_reg <= ctl.sel;
            CMD_SETUP:
            begin
                count_reg <= AREA_W'(ex_reg - bx_reg) * AREA_W'(ey_reg - by_reg);
                sx_reg    <= bx_reg;
                sy_reg    <= by_reg;
                ch_reg    <= '0;
                for (int k = 0; k < NUM_CH; k++)
                    sum_reg[k] <= '0;
            end
            CMD_READ:
            begin
                last_reg <= (sx_reg == ex_reg - 1'b1) && (sy_reg == ey_reg - 1'b1);
                if (sx_reg == ex_reg - 1'b1)
                begin
                    sx_reg <= bx_reg;
                    sy_reg <= sy_reg + 1'b1;
                end
                else
                    sx_reg <= sx_reg + 1'b1;
            end
            CMD_ACC:
            begin
                for (int k = 0; k < NUM_CH; k++)
                    sum_reg[k] <= sum_reg[k] + add_val[k];
            end
            CMD_SEARCH_INIT:
            begin
                lo_reg <= '0;
                hi_reg <= SIZE_W'(ROM_DEPTH);
            end
            CMD_SEARCH_MUL:
                prod_reg <= PROD_W'(LIN_ROM[mid]) * PROD_W'(count_reg);
            CMD_SEARCH_CMP:
            begin
                if (prod_reg >= PROD_W'(cur_sum))
                    hi_reg <= SIZE_W'(mid);
                else
                    lo_reg <= SIZE_W'(mid) + 1'b1;
            end
            CMD_MUL_UP:
                prod_reg <= PROD_W'(LIN_ROM[lo_reg[7:0]]) * PROD_W'(count_reg);
            CMD_MUL_DN:
            begin
                up_reg   <= prod_reg;
                prod_reg <= PROD_W'(LIN_ROM[lo_reg[7:0] - 1'b1]) * PROD_W'(count_reg);
            end
            CMD_SRGB_DONE:
            begin
                if (lo_reg == '0)
                    res_reg[ch_reg] <= '0;
                else if (lo_reg[8])
                    res_reg[ch_reg] <= '1;
                else if (up_gap < dn_gap)
                    res_reg[ch_reg] <= lo_reg[7:0];
                else
                    res_reg[ch_reg] <= lo_reg[7:0] - 1'b1;
            end
            CMD_NEXT_CH:
                ch_reg <= ch_reg + 1'b1;
            default: ;
        endcase
    end

    // result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.cmd == CMD_PUBLISH)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cmd == CMD_PUBLISH)
        begin
            for (int k = 0; k < NUM_CH; k++)
                out_ch_reg[k] <= res_reg[k];
            out_bad_reg <= res_bad_reg;
        end
    end

    assign stat.query       = action;
    assign stat.bad         = res_bad_reg;
    assign stat.div_done    = div_done;
    assign stat.last        = last_reg;
    assign stat.ch_used     = {1'b0, ch_reg} < nch;
    assign stat.ch_srgb     = srgb_of(ch_reg, nch, color_semantic_reg, srgb_space_reg);
    assign stat.ch_last     = ch_reg == 2'(NUM_CH - 1);
    assign stat.search_done = lo_reg == hi_reg;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_ch0   = out_ch_reg[0];
    assign out_ch1   = out_ch_reg[1];
    assign out_ch2   = out_ch_reg[2];
    assign out_ch3   = out_ch_reg[3];
    assign bad_coord = out_bad_reg;

endmodule

/* design/ldrbox_ctrl.sv */
// Controller: sequences bounds, box walk, per-channel resolve and result transfer.
module ldrbox_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ldrbox_pkg::dp_stat_t stat,
    output ldrbox_pkg::dp_ctl_t  ctl
);
    import ldrbox_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_WBX,
        S_WEX,
        S_WBY,
        S_WEY,
        S_SETUP,
        S_RD,
        S_ACC,
        S_CH,
        S_WMEAN,
        S_SMUL,
        S_SCMP,
        S_MDN,
        S_SDONE,
        S_NEXT,
        S_PUB
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctl.cmd    = CMD_NOP;
        ctl.sel    = DIV_BX;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.query)
                    begin
                        ctl.cmd    = CMD_CAPTURE;
                        state_next = S_CHECK;
                    end
                    else
                        ctl.cmd = CMD_LOAD;
                end
            end
            S_CHECK:
            begin
                if (stat.bad)
                    state_next = S_PUB;
                else
                begin
                    ctl.cmd    = CMD_DIV;
                    ctl.sel    = DIV_BX;
                    state_next = S_WBX;
                end
            end
            S_WBX:
            begin
                if (stat.div_done)
                begin
                    ctl.cmd    = CMD_DIV;
                    ctl.sel    = DIV_EX;
                    state_next = S_WEX;
                end
            end
            S_WEX:
            begin
                if (stat.div_done)
                begin
                    ctl.cmd    = CMD_DIV;
                    ctl.sel    = DIV_BY;
                    state_next = S_WBY;
                end
            end
            S_WBY:
            begin
                if (stat.div_done)
                begin
                    ctl.cmd    = CMD_DIV;
                    ctl.sel    = DIV_EY;
                    state_next = S_WEY;
                end
            end
            S_WEY:
            begin
                if (stat.div_done)
                    state_next = S_SETUP;
            end
            S_SETUP:
            begin
                ctl.cmd    = CMD_SETUP;
                state_next = S_RD;
            end
            S_RD:
            begin
                ctl.cmd    = CMD_READ;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                ctl.cmd    = CMD_ACC;
                state_next = stat.last ? S_CH : S_RD;
            end
            S_CH:
            begin
                if (!stat.ch_used)
                    state_next = S_NEXT;
                else if (stat.ch_srgb)
                begin
                    ctl.cmd    = CMD_SEARCH_INIT;
                    state_next = S_SMUL;
                end
                else
                begin
                    ctl.cmd    = CMD_DIV;
                    ctl.sel    = DIV_MEAN;
                    state_next = S_WMEAN;
                end
            end
            S_WMEAN:
            begin
                ctl.sel = DIV_MEAN;
                if (stat.div_done)
                    state_next = S_NEXT;
            end
            S_SMUL:
            begin
                if (stat.search_done)
                begin
                    ctl.cmd    = CMD_MUL_UP;
                    state_next = S_MDN;
                end
                else
                begin
                    ctl.cmd    = CMD_SEARCH_MUL;
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                ctl.cmd    = CMD_SEARCH_CMP;
                state_next = S_SMUL;
            end
            S_MDN:
            begin
                ctl.cmd    = CMD_MUL_DN;
                state_next = S_SDONE;
            end
            S_SDONE:
            begin
                ctl.cmd    = CMD_SRGB_DONE;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (stat.ch_last)
                    state_next = S_PUB;
                else
                begin
                    ctl.cmd    = CMD_NEXT_CH;
                    state_next = S_CH;
                end
            end
            S_PUB:
            begin
                if (stat.out_free)
                begin
                    ctl.cmd    = CMD_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign in_ready = state_reg == S_IDLE;

endmodule

/* design/ldr_box_downsample_srgb.sv */
// Top level of the 8-bit box-filter downsampler with sRGB-aware averaging.
// A load transfer writes one texel into the image store. A query runs the four
// bound divisions on the shared one-bit-per-cycle divider, then a store read and
// an accumulate per source texel in its box, then per used channel a plain
// rounded mean or the sRGB inverse-table search. A finished result waits in an
// output register, so the next item is taken while it is still unclaimed. The
// image store has no reset; query only written texels.
module ldr_box_downsample_srgb #(
    parameter int MAX_WIDTH  = ldrbox_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ldrbox_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic [ldrbox_pkg::BYTE_W-1:0]     texel_x,
    input  logic [ldrbox_pkg::BYTE_W-1:0]     texel_y,
    input  logic [ldrbox_pkg::BYTE_W-1:0]     in_ch0,
    input  logic [ldrbox_pkg::BYTE_W-1:0]     in_ch1,
    input  logic [ldrbox_pkg::BYTE_W-1:0]     in_ch2,
    input  logic [ldrbox_pkg::BYTE_W-1:0]     in_ch3,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ldrbox_pkg::BYTE_W-1:0]     out_ch0,
    output logic [ldrbox_pkg::BYTE_W-1:0]     out_ch1,
    output logic [ldrbox_pkg::BYTE_W-1:0]     out_ch2,
    output logic [ldrbox_pkg::BYTE_W-1:0]     out_ch3,
    output logic                              bad_coord,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ldrbox_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ldrbox_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ldrbox_pkg::*;

    dp_ctl_t  ctl;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    ldrbox_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    ldrbox_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .action    (action),
        .texel_x   (texel_x),
        .texel_y   (texel_y),
        .in_ch0    (in_ch0),
        .in_ch1    (in_ch1),
        .in_ch2    (in_ch2),
        .in_ch3    (in_ch3),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_ch0   (out_ch0),
        .out_ch1   (out_ch1),
        .out_ch2   (out_ch2),
        .out_ch3   (out_ch3),
        .bad_coord (bad_coord)
    );

endmodule

/* tb/ldr_box_downsample_srgb_tb.sv */
// Testbench for the sRGB-aware box downsampler: directed table, then random phases.
`timescale 1ns / 100ps

module ldr_box_downsample_srgb_tb;
    import ldrbox_pkg::*;

    localparam bit             ACT_LOAD   = 1'b0;
    localparam bit             ACT_QUERY  = 1'b1;
    localparam logic [2:0]     REG_UNUSED = 3'd7;
    localparam int             STORE_W    = 256;
    localparam int             STORE_H    = 256;
    localparam longint         CYCLE_LIMIT = 10000000;

    typedef struct packed {
        logic [31:0] ch;
        logic        bad;
    } texel_out_t;

    typedef struct packed {
        logic        act;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [31:0] data;
        logic        chk;
        logic [31:0] exp_ch;
        logic        exp_bad;
    } dir_row_t;

    typedef struct packed {
        logic [8:0] sw;
        logic [8:0] sh;
        logic [8:0] dw;
        logic [8:0] dh;
        logic [2:0] nch;
        logic       cs;
        logic       sr;
    } cfg_set_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic action = 1'b0;
    logic [7:0] texel_x = '0, texel_y = '0;
    logic [7:0] in_ch0 = '0, in_ch1 = '0, in_ch2 = '0, in_ch3 = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] out_ch0, out_ch1, out_ch2, out_ch3;
    logic bad_coord;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ldr_box_downsample_srgb u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .action(action),
        .texel_x(texel_x), .texel_y(texel_y),
        .in_ch0(in_ch0), .in_ch1(in_ch1), .in_ch2(in_ch2), .in_ch3(in_ch3),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_ch0(out_ch0), .out_ch1(out_ch1), .out_ch2(out_ch2), .out_ch3(out_ch3),
        .bad_coord(bad_coord),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    int unsigned  lin_lut [256];
    logic [31:0]  src_img [STORE_W*STORE_H];
    bit           src_written [STORE_W*STORE_H];
    cfg_set_t     cur_cfg;
    texel_out_t   pending_texels [$];
    int           errors = 0;
    bit           quiet = 1'b0;
    int           out_stall = 0;
    longint       cycles = 0;

    // round(2^24 * (num/269025)^2.4) by exact integer search
    function automatic int unsigned srgb_pow_q24(int unsigned num);
        bit [447:0] rhs, lhs;
        int unsigned lo, hi, mid;
        rhs = 448'd1;
        lo = 0;
        hi = (1 << 25) + 1;
        repeat (12) rhs = rhs * 448'(num);
        rhs = rhs << 125;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            lhs = 448'd1;
            repeat (5) lhs = lhs * 448'(mid);
            repeat (12) lhs = lhs * 448'd269025;
            if (lhs <= rhs) lo = mid;
            else hi = mid;
        end
        return (lo + 1) >> 1;
    endfunction

    function automatic int unsigned linear_to_srgb(longint unsigned sum, longint unsigned cnt);
        int unsigned i;
        longint unsigned up, dn;
        i = 0;
        while (i < 256 && longint'(lin_lut[i]) * cnt < sum) i++;
        if (i == 0) return 0;
        if (i == 256) return 255;
        up = longint'(lin_lut[i]) * cnt;
        dn = longint'(lin_lut[i-1]) * cnt;
        return (up - sum < sum - dn) ? i : i - 1;
    endfunction

    function automatic int unsigned src_eff(logic [8:0] v, int unsigned maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic void box_span(int unsigned d, int unsigned dsz, int unsigned ssz,
                                     output int unsigned b, output int unsigned e);
        longint unsigned lo, hi;
        lo = longint'(d) * ssz / dsz;
        hi = (longint'(d + 1) * ssz + dsz - 1) / dsz;
        if (hi > ssz) hi = ssz;
        if (hi < lo + 1) hi = lo + 1;
        b = lo;
        e = hi;
    endfunction

    function automatic texel_out_t box_average(int unsigned x, int unsigned y);
        texel_out_t r;
        int unsigned sw, sh, dw, dh, nch, bx, ex, by, ey;
        longint unsigned cnt, sum;
        logic [7:0] b;
        bit alpha, srgb;
        r = '0;
        sw = src_eff(cur_cfg.sw, STORE_W);
        sh = src_eff(cur_cfg.sh, STORE_H);
        dw = (cur_cfg.dw == 0) ? 1 : cur_cfg.dw;
        dh = (cur_cfg.dh == 0) ? 1 : cur_cfg.dh;
        nch = (cur_cfg.nch == 0) ? 1 : (cur_cfg.nch > 4 ? 4 : cur_cfg.nch);
        if (x >= dw || y >= dh) begin
            r.bad = 1'b1;
            return r;
        end
        box_span(x, dw, sw, bx, ex);
        box_span(y, dh, sh, by, ey);
        cnt = longint'(ex - bx) * (ey - by);
        for (int c = 0; c < nch; c++) begin
            alpha = cur_cfg.cs && ((nch == 2 && c == 1) || (nch == 4 && c == 3));
            srgb = cur_cfg.cs && cur_cfg.sr && !alpha;
            sum = 0;
            for (int sy = by; sy < ey; sy++)
                for (int sx = bx; sx < ex; sx++) begin
                    b = src_img[sy*STORE_W + sx][8*c +: 8];
                    sum += srgb ? lin_lut[b] : b;
                end
            r.ch[8*c +: 8] = srgb ? 8'(linear_to_srgb(sum, cnt)) : 8'((sum + cnt/2) / cnt);
        end
        return r;
    endfunction

    // input transfer; a query queues its table result when chk is set, else a predicted one
    task automatic send_item(input dir_row_t it);
        int gap;
        texel_out_t exp_res;
        gap = quiet ? 0 : $urandom_range(0, 14);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        action <= it.act;
        texel_x <= it.x;
        texel_y <= it.y;
        {in_ch3, in_ch2, in_ch1, in_ch0} <= it.data;
        do @(posedge clk); while (!in_ready);
        if (it.act == ACT_LOAD) begin
            src_img[it.y*STORE_W + it.x] = it.data;
            src_written[it.y*STORE_W + it.x] = 1'b1;
        end
        else begin
            if (it.chk)
                exp_res = {it.exp_ch, it.exp_bad};
            else
                exp_res = box_average(it.x, it.y);
            pending_texels.insert(pending_texels.size(), exp_res);
        end
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [8:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_texels.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic run_phase(input cfg_set_t c, input int n_items);
        dir_row_t it;
        int unsigned sw, sh, dw, dh;
        wait_idle();
        quiet = ($urandom_range(0, 3) == 0);
        cfg_write(REG_SRC_WIDTH, c.sw);
        cfg_write(REG_SRC_HEIGHT, c.sh);
        cfg_write(REG_DST_WIDTH, c.dw);
        cfg_write(REG_DST_HEIGHT, c.dh);
        cfg_write(REG_CHANNEL_COUNT, 9'(c.nch));
        cfg_write(REG_COLOR_SEMANTIC, 9'(c.cs));
        cfg_write(REG_SRGB_SPACE, 9'(c.sr));
        if ($urandom_range(0, 2) == 0) cfg_write(REG_UNUSED, 9'($urandom_range(0, 511)));
        cur_cfg = c;
        sw = src_eff(c.sw, STORE_W);
        sh = src_eff(c.sh, STORE_H);
        dw = (c.dw == 0) ? 1 : c.dw;
        dh = (c.dh == 0) ? 1 : c.dh;
        it = '0;
        it.act = ACT_LOAD;
        // every texel a query can read must be written first
        for (int y = 0; y < sh; y++)
            for (int x = 0; x < sw; x++)
                if (!src_written[y*STORE_W + x] || $urandom_range(0, 3) == 0) begin
                    it.x = x;
                    it.y = y;
                    it.data = $urandom;
                    send_item(it);
                end
        for (int n = 0; n < n_items; n++) begin
            it = '0;
            it.data = $urandom;
            if ($urandom_range(0, 9) < 3) begin
                it.act = ACT_LOAD;
                it.x = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, sw-1);
                it.y = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, sh-1);
            end
            else begin
                it.act = ACT_QUERY;
                it.x = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, (dw > 256 ? 256 : dw) - 1);
                it.y = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, (dh > 256 ? 256 : dh) - 1);
            end
            send_item(it);
        end
    endtask

    function automatic logic [8:0] rand_size();
        if ($urandom_range(0, 9) == 0) return 9'd0;
        return 9'($urandom_range(1, 16));
    endfunction

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) out_ready <= 1'b0;
        else if (out_stall > 0) begin
            out_ready <= 1'b0;
            out_stall--;
        end
        else out_ready <= 1'b1;
    end

    always @(posedge clk) begin
        texel_out_t want, got;
        if (rst_n && out_valid && out_ready) begin
            got = {out_ch3, out_ch2, out_ch1, out_ch0, bad_coord};
            if (pending_texels.size() == 0) begin
                $display("%0t: result transfer with none expected: ch %h bad %b",
                         $time, got.ch, got.bad);
                errors++;
            end
            else begin
                want = pending_texels.pop_front();
                for (int c = 0; c < 4; c++)
                    if (want.ch[8*c +: 8] !== got.ch[8*c +: 8]) begin
                        $display("%0t: out_ch%0d expected %h actual %h",
                                 $time, c, want.ch[8*c +: 8], got.ch[8*c +: 8]);
                        errors++;
                    end
                if (want.bad !== got.bad) begin
                    $display("%0t: bad_coord expected %b actual %b", $time, want.bad, got.bad);
                    errors++;
                end
            end
            out_stall = quiet ? 0 : $urandom_range(0, 14);
        end
    end

    dir_row_t dir_tab [10] = '{
        '{ACT_LOAD,  8'd0,   8'd0,   32'h0180FF00, 1'b0, 32'h0,        1'b0},
        '{ACT_QUERY, 8'd0,   8'd0,   32'h0,        1'b1, 32'h0180FF00, 1'b0},
        '{ACT_LOAD,  8'd0,   8'd0,   32'hFE7F00FF, 1'b0, 32'h0,        1'b0},
        '{ACT_QUERY, 8'd0,   8'd0,   32'h0,        1'b1, 32'hFE7F00FF, 1'b0},
        '{ACT_QUERY, 8'd1,   8'd0,   32'hFFFFFFFF, 1'b1, 32'h0,        1'b1},
        '{ACT_QUERY, 8'd0,   8'd1,   32'h0,        1'b1, 32'h0,        1'b1},
        '{ACT_QUERY, 8'd255, 8'd255, 32'h0,        1'b1, 32'h0,        1'b1},
        '{ACT_LOAD,  8'd255, 8'd255, 32'hA55AC33C, 1'b0, 32'h0,        1'b0},
        '{ACT_LOAD,  8'd255, 8'd0,   32'hFFFFFFFF, 1'b0, 32'h0,        1'b0},
        '{ACT_QUERY, 8'd0,   8'd0,   32'h0,        1'b0, 32'h0,        1'b0}
    };

    initial begin
        cfg_set_t c;
        for (int i = 0; i < 256; i++)
            lin_lut[i] = (i <= 10) ? int'((longint'(i) * 335544320 + 32946) / 65892)
                                   : srgb_pow_q24(i * 1000 + 14025);
        cur_cfg = '{9'd1, 9'd1, 9'd1, 9'd1, 3'd4, 1'b1, 1'b1};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i]) send_item(dir_tab[i]);

        run_phase('{9'd256, 9'd1,   9'd256, 9'd1,   3'd4, 1'b1, 1'b1}, 60);
        run_phase('{9'd256, 9'd1,   9'd1,   9'd1,   3'd3, 1'b1, 1'b1}, 6);
        run_phase('{9'd1,   9'd256, 9'd0,   9'd7,   3'd2, 1'b1, 1'b0}, 60);
        run_phase('{9'd300, 9'd2,   9'd511, 9'd1,   3'd0, 1'b0, 1'b1}, 40);
        run_phase('{9'd3,   9'd5,   9'd256, 9'd256, 3'd5, 1'b1, 1'b1}, 80);
        run_phase('{9'd0,   9'd0,   9'd0,   9'd0,   3'd7, 1'b0, 1'b0}, 40);
        for (int p = 0; p < 12; p++) begin
            c.sw = rand_size();
            c.sh = rand_size();
            c.dw = rand_size();
            c.dh = rand_size();
            c.nch = $urandom_range(0, 7);
            c.cs = $urandom_range(0, 1);
            c.sr = $urandom_range(0, 1);
            run_phase(c, 30);
        end

        wait_idle();
        repeat (250) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
